@@ hw/rtl/qrs_pkg.sv @@
// Quadratic root solver: shared widths, result kind codes and the context record
// that travels down the pipeline. No dependencies.
package qrs_pkg;

    localparam int COEF_W    = 16;
    localparam int COEF_FRAC = 8;
    localparam int OUT_FRAC  = 16;
    localparam int OUT_W     = 40;
    localparam int DISC_W    = 34;
    localparam int MAG_W     = COEF_W + 1;
    localparam int SQ_W      = 2 * MAG_W;
    localparam int DMAG_W    = 34;
    localparam int ROOT_W    = 33;
    localparam int RAD_W     = 2 * ROOT_W;
    localparam int SREM_W    = ROOT_W + 2;
    localparam int NUM_W     = 48;
    localparam int DEN_W     = 26;
    localparam int LANES     = 3;

    typedef enum logic [1:0] {
        KIND_A_ZERO   = 2'd0,
        KIND_DOUBLE   = 2'd1,
        KIND_TWO_REAL = 2'd2,
        KIND_COMPLEX  = 2'd3
    } kind_t;

    typedef struct packed {
        logic                      a_zero;
        logic                      a_neg;
        logic                      b_neg;
        kind_t                     kind;
        logic signed [DISC_W-1:0]  disc;
        logic signed [COEF_W-1:0]  c;
        logic [MAG_W-1:0]          am;
        logic [MAG_W-1:0]          bm;
        logic [SQ_W-1:0]           sq;
    } ctx_t;

endpackage

@@ hw/rtl/qrs_sqrt_pipe.sv @@
// Quadratic root solver: pipelined integer square root, one root bit per stage.
// Uses qrs_pkg; carries the request context alongside.
module qrs_sqrt_pipe
    import qrs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_valid,
    input  logic [RAD_W-1:0]   radicand,
    input  ctx_t               in_ctx,
    output logic               out_valid,
    output logic [ROOT_W-1:0]  root,
    output ctx_t               out_ctx
);

    logic              valid_reg [ROOT_W];
    logic [SREM_W-1:0] rem_reg   [ROOT_W];
    logic [ROOT_W-1:0] root_reg  [ROOT_W];
    logic [RAD_W-1:0]  rad_reg   [ROOT_W];
    ctx_t              ctx_reg   [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic              v_in;
        logic [SREM_W-1:0] rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [RAD_W-1:0]  rad_in;
        ctx_t              ctx_in;
        logic [SREM_W-1:0] t;
        logic [SREM_W-1:0] trial;
        logic              ge;
        logic [SREM_W-1:0] rem_next;
        logic [ROOT_W-1:0] root_next;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = radicand;
            assign ctx_in  = in_ctx;
        end
        else begin : g_rest
            assign v_in    = valid_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign ctx_in  = ctx_reg[k-1];
        end

        always_comb
        begin
            t         = {rem_in[SREM_W-3:0], rad_in[RAD_W-1 -: 2]};
            trial     = {root_in, 2'b01};
            ge        = (t >= trial);
            rem_next  = ge ? (t - trial) : t;
            root_next = {root_in[ROOT_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                rad_reg[k]  <= {rad_in[RAD_W-3:0], 2'b00};
                ctx_reg[k]  <= ctx_in;
            end
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];
    assign out_ctx   = ctx_reg[ROOT_W-1];

endmodule

@@ hw/rtl/qrs_div_pipe.sv @@
// Quadratic root solver: three-lane pipelined restoring divider, one quotient
// bit per stage per lane. Uses qrs_pkg; carries the request context alongside.
module qrs_div_pipe
    import qrs_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  logic                         in_valid,
    input  logic [LANES-1:0][NUM_W-1:0]  num,
    input  logic [LANES-1:0][DEN_W-1:0]  den,
    input  ctx_t                         in_ctx,
    output logic                         out_valid,
    output logic [LANES-1:0][NUM_W-1:0]  quot,
    output ctx_t                         out_ctx
);

    logic                        valid_reg [NUM_W];
    logic [LANES-1:0][DEN_W-1:0] rem_reg   [NUM_W];
    logic [LANES-1:0][NUM_W-1:0] q_reg     [NUM_W];
    logic [LANES-1:0][NUM_W-1:0] n_reg     [NUM_W];
    logic [LANES-1:0][DEN_W-1:0] d_reg     [NUM_W];
    ctx_t                        ctx_reg   [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic                        v_in;
        logic [LANES-1:0][DEN_W-1:0] rem_in;
        logic [LANES-1:0][NUM_W-1:0] q_in;
        logic [LANES-1:0][NUM_W-1:0] n_in;
        logic [LANES-1:0][DEN_W-1:0] d_in;
        ctx_t                        ctx_in;
        logic [LANES-1:0][DEN_W-1:0] rem_next;
        logic [LANES-1:0][NUM_W-1:0] q_next;
        logic [LANES-1:0][NUM_W-1:0] n_next;

        if (k == 0) begin : g_first
            assign v_in   = in_valid;
            assign rem_in = '0;
            assign q_in   = '0;
            assign n_in   = num;
            assign d_in   = den;
            assign ctx_in = in_ctx;
        end
        else begin : g_rest
            assign v_in   = valid_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign n_in   = n_reg[k-1];
            assign d_in   = d_reg[k-1];
            assign ctx_in = ctx_reg[k-1];
        end

        always_comb
        begin
            logic [DEN_W:0] t;
            logic           ge;
            for (int l = 0; l < LANES; l++)
            begin
                t           = {rem_in[l], n_in[l][NUM_W-1]};
                ge          = (t >= {1'b0, d_in[l]});
                rem_next[l] = ge ? DEN_W'(t - {1'b0, d_in[l]}) : t[DEN_W-1:0];
                q_next[l]   = {q_in[l][NUM_W-2:0], ge};
                n_next[l]   = {n_in[l][NUM_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k] <= rem_next;
                q_reg[k]   <= q_next;
                n_reg[k]   <= n_next;
                d_reg[k]   <= d_in;
                ctx_reg[k] <= ctx_in;
            end
        end
    end

    assign out_valid = valid_reg[NUM_W-1];
    assign quot      = q_reg[NUM_W-1];
    assign out_ctx   = ctx_reg[NUM_W-1];

endmodule

@@ hw/rtl/quadratic_root_solver_core.sv @@
// Quadratic root solver top level: front products, discriminant, square root
// and divider pipelines, result register. Uses qrs_pkg, qrs_sqrt_pipe, qrs_div_pipe.
//
//  channel   handshake               payload
//  input     in_valid / in_ready     coef_a, coef_b, coef_c
//  output    out_valid / out_ready   root_kind, discriminant, axis_x, vertex_y,
//                                    first_part, second_part
//
// One request per cycle while no result is held; stages: products, discriminant,
// 33 square root stages, 48 divider stages, result register.
// All stages move together; a held result freezes the whole pipe, nothing lost.
// Reset clears the valid bits only.
module quadratic_root_solver_core
    import qrs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [COEF_W-1:0] coef_a,
    input  logic signed [COEF_W-1:0] coef_b,
    input  logic signed [COEF_W-1:0] coef_c,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [1:0]               root_kind,
    output logic signed [DISC_W-1:0] discriminant,
    output logic signed [OUT_W-1:0]  axis_x,
    output logic signed [OUT_W-1:0]  vertex_y,
    output logic signed [OUT_W-1:0]  first_part,
    output logic signed [OUT_W-1:0]  second_part
);

    logic adv;

    // stage 0: magnitudes and products
    logic                       s0_valid_reg;
    logic                       s0_a_neg_reg, s0_b_neg_reg, s0_a_zero_reg;
    logic [MAG_W-1:0]           s0_am_reg, s0_bm_reg;
    logic signed [COEF_W-1:0]   s0_c_reg;
    logic [SQ_W-1:0]            s0_sq_reg;
    logic signed [2*COEF_W-1:0] s0_ac_reg;
    logic signed [MAG_W-1:0]    a_ext, b_ext;
    logic [MAG_W-1:0]           am_next, bm_next;

    // stage 1: discriminant
    logic                       s1_valid_reg;
    ctx_t                       s1_ctx_reg;
    logic [DMAG_W-1:0]          s1_dmag_reg;
    logic signed [DISC_W+1:0]   disc_full;
    logic [DISC_W+1:0]          dmag_full;
    ctx_t                       ctx_next;

    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    ctx_t              sq_ctx;

    logic [LANES-1:0][NUM_W-1:0] dv_num;
    logic [LANES-1:0][DEN_W-1:0] dv_den;
    logic [LANES-1:0][NUM_W-1:0] dv_quot;
    logic                        dv_valid;
    ctx_t                        dv_ctx;

    logic                     out_valid_reg;
    logic [1:0]               kind_reg;
    logic signed [DISC_W-1:0] disc_reg;
    logic signed [OUT_W-1:0]  axis_reg, vert_reg, first_reg, second_reg;
    logic [1:0]               kind_next;
    logic signed [DISC_W-1:0] disc_next;
    logic signed [OUT_W-1:0]  axis_next, vert_next, first_next, second_next;
    logic signed [OUT_W-1:0]  qa, qv, qs, irr, cterm;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    always_comb
    begin
        a_ext   = MAG_W'(coef_a);
        b_ext   = MAG_W'(coef_b);
        am_next = a_ext[MAG_W-1] ? MAG_W'(-a_ext) : MAG_W'(a_ext);
        bm_next = b_ext[MAG_W-1] ? MAG_W'(-b_ext) : MAG_W'(b_ext);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_valid_reg  <= in_valid;
            s1_valid_reg  <= s0_valid_reg;
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_a_neg_reg  <= coef_a[COEF_W-1];
            s0_b_neg_reg  <= coef_b[COEF_W-1];
            s0_a_zero_reg <= (coef_a == '0);
            s0_am_reg     <= am_next;
            s0_bm_reg     <= bm_next;
            s0_c_reg      <= coef_c;
            s0_sq_reg     <= bm_next * bm_next;
            s0_ac_reg     <= coef_a * coef_c;
        end
    end

    // b^2 - 4ac, exact
    always_comb
    begin
        disc_full = (DISC_W+2)'($signed({1'b0, s0_sq_reg}))
                    - ((DISC_W+2)'(s0_ac_reg) <<< 2);
        dmag_full = disc_full[DISC_W+1] ? (DISC_W+2)'(-disc_full) : disc_full;
        ctx_next.a_zero = s0_a_zero_reg;
        ctx_next.a_neg  = s0_a_neg_reg;
        ctx_next.b_neg  = s0_b_neg_reg;
        ctx_next.disc   = disc_full[DISC_W-1:0];
        ctx_next.c      = s0_c_reg;
        ctx_next.am     = s0_am_reg;
        ctx_next.bm     = s0_bm_reg;
        ctx_next.sq     = s0_sq_reg;
        if (s0_a_zero_reg)
        begin
            ctx_next.kind = KIND_A_ZERO;
        end
        else if (disc_full == '0)
        begin
            ctx_next.kind = KIND_DOUBLE;
        end
        else if (disc_full[DISC_W+1])
        begin
            ctx_next.kind = KIND_COMPLEX;
        end
        else
        begin
            ctx_next.kind = KIND_TWO_REAL;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ctx_reg  <= ctx_next;
            s1_dmag_reg <= dmag_full[DMAG_W-1:0];
        end
    end

    qrs_sqrt_pipe u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s1_valid_reg),
        .radicand  ({s1_dmag_reg, (RAD_W-DMAG_W)'(0)}),
        .in_ctx    (s1_ctx_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_ctx   (sq_ctx)
    );

    // lanes: axis -b/2a, vertex b^2/4a, root spread sqrt/2a
    always_comb
    begin
        dv_num[0] = NUM_W'({sq_ctx.bm, OUT_FRAC'(0)});
        dv_den[0] = DEN_W'({sq_ctx.am, 1'b0});
        dv_num[1] = NUM_W'({sq_ctx.sq, OUT_FRAC'(0)});
        dv_den[1] = DEN_W'({sq_ctx.am, (2+COEF_FRAC)'(0)});
        dv_num[2] = NUM_W'(sq_root);
        dv_den[2] = DEN_W'({sq_ctx.am, 1'b0});
    end

    qrs_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sq_valid),
        .num       (dv_num),
        .den       (dv_den),
        .in_ctx    (sq_ctx),
        .out_valid (dv_valid),
        .quot      (dv_quot),
        .out_ctx   (dv_ctx)
    );

    always_comb
    begin
        qa    = $signed(dv_quot[0][OUT_W-1:0]);
        qv    = $signed(dv_quot[1][OUT_W-1:0]);
        qs    = $signed(dv_quot[2][OUT_W-1:0]);
        irr   = dv_ctx.a_neg ? -qs : qs;
        cterm = OUT_W'(dv_ctx.c) <<< (OUT_FRAC - COEF_FRAC);
        axis_next = (dv_ctx.b_neg != dv_ctx.a_neg) ? qa : -qa;
        vert_next = cterm - (dv_ctx.a_neg ? -qv : qv);
        kind_next = dv_ctx.kind;
        disc_next = dv_ctx.disc;
        case (dv_ctx.kind)
            KIND_TWO_REAL:
            begin
                first_next  = axis_next + irr;
                second_next = axis_next - irr;
            end
            KIND_COMPLEX:
            begin
                first_next  = axis_next;
                second_next = qs;
            end
            KIND_DOUBLE:
            begin
                first_next  = axis_next;
                second_next = axis_next;
            end
            default:
            begin
                axis_next   = '0;
                vert_next   = '0;
                disc_next   = '0;
                first_next  = '0;
                second_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kind_reg   <= kind_next;
            disc_reg   <= disc_next;
            axis_reg   <= axis_next;
            vert_reg   <= vert_next;
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign root_kind    = kind_reg;
    assign discriminant = disc_reg;
    assign axis_x       = axis_reg;
    assign vertex_y     = vert_reg;
    assign first_part   = first_reg;
    assign second_part  = second_reg;

    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow output stall");

    a_zero_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && root_kind == KIND_A_ZERO) |->
        (discriminant == '0 && axis_x == '0 && vertex_y == '0
         && first_part == '0 && second_part == '0))
        else $error("zero a result not cleared");

    a_double_disc: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && root_kind == KIND_DOUBLE) |->
        (discriminant == '0 && first_part == axis_x && second_part == axis_x))
        else $error("double root inconsistent");

    a_complex_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && root_kind == KIND_COMPLEX) |->
        (discriminant[DISC_W-1] && !second_part[OUT_W-1] && first_part == axis_x))
        else $error("complex pair inconsistent");

endmodule
